[sv/pal_pkg.sv]
// Shared types, constants and codes for the periodic alarm list.
// Used by pal_head, pal_cell and periodic_alarm_list_unit; depends on nothing.
`timescale 1ns / 1ps

package pal_pkg;

  // Default table depth and the cap on fire results per tick.
  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int FIRE_CNT_W    = $clog2(MAX_RESULTS + 1);

  // Reset value of the lateness window.
  localparam logic [15:0] LATE_WINDOW_RST = 16'd15;

  // Command codes.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_REG   = 2'd1;
  localparam logic [1:0] CMD_UNREG = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // Result kinds.
  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_DUP       = 2'd3;

  // Input transaction.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  alarm_id;
    logic [31:0] first_due;
    logic [31:0] period;
    logic [31:0] now;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic        kind;
    logic [7:0]  fired_id;
    logic [31:0] next_due;
    logic [1:0]  status;
    logic        last;
  } rsp_t;

  // One table slot.
  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [31:0] due;
    logic [31:0] period;
  } entry_t;

  // Per-cycle control handed to every cell.
  typedef struct packed {
    logic step;
    logic compact;
  } cell_ctl_t;

  // Flags gathered over one pass of the table.
  typedef struct packed {
    logic dup;
    logic placed;
    logic found;
  } scan_flags_t;

  // What the head unit decides about the entry at the head of the chain.
  typedef struct packed {
    logic fire;
    logic match;
    logic place;
  } head_res_t;

endpackage

[sv/pal_cell.sv]
// One slot of the alarm table, a link of the rotating cell chain.
// Depends on pal_pkg for the entry and control types.
`timescale 1ns / 1ps

module pal_cell #(
  parameter int IDX   = 0,
  parameter int POS_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  pal_pkg::cell_ctl_t ctl,
  input  logic [POS_W-1:0]   pos,
  input  pal_pkg::entry_t    nb,
  output pal_pkg::entry_t    q
);
  import pal_pkg::*;

  localparam logic [POS_W-1:0] IDX_V = POS_W'(IDX);

  logic en;

  // Take the neighbour's entry on a rotation step, or when closing up behind a removed slot.
  assign en = ctl.step | (ctl.compact & (IDX_V >= pos));

  // Valid flag is control state and is cleared by reset.
  // Payload needs no reset; it is only read while the slot is valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= nb.valid;
    end
    if (en) begin
      q.id     <= nb.id;
      q.due    <= nb.due;
      q.period <= nb.period;
    end
  end

endmodule

[sv/pal_head.sv]
// Evaluation of the entry at the head of the cell chain during a pass.
// Depends on pal_pkg; produces the entry fed back into the tail cell.
`timescale 1ns / 1ps

module pal_head (
  input  logic [1:0]           cmd,
  input  logic [7:0]           job_id,
  input  logic [31:0]          first_due,
  input  logic [31:0]          period,
  input  logic [31:0]          now,
  input  logic [15:0]          window,
  input  pal_pkg::entry_t      head,
  input  pal_pkg::scan_flags_t flg,
  output pal_pkg::entry_t      fb,
  output pal_pkg::head_res_t   res
);
  import pal_pkg::*;

  logic [31:0] late;
  logic [31:0] due_adv;

  // Wrap-around lateness and the advanced due time.
  assign late    = now - head.due;
  assign due_adv = head.due + head.period;

  // Decisions for the current head entry.
  always_comb begin
    res.fire  = (cmd == CMD_TICK) && head.valid && (late <= {16'd0, window});
    res.match = head.valid && (head.id == job_id) &&
                ((cmd == CMD_REG) || ((cmd == CMD_UNREG) && !flg.found));
    // Valid slots form a prefix, so the first free slot comes after every id check.
    res.place = (cmd == CMD_REG) && !head.valid && !flg.placed && !flg.dup;
  end

  // Entry written back at the tail.
  always_comb begin
    fb = head;
    if (res.fire) begin
      fb.due = due_adv;
    end
    if (res.place) begin
      fb.valid  = 1'b1;
      fb.id     = job_id;
      fb.due    = first_due;
      fb.period = period;
    end
  end

endmodule

[sv/periodic_alarm_list_unit.sv]
// Periodic alarm list: each command other than NOP rotates the table once through a chain of cells.
// The last result follows the rotation and the finish state, and is held back while results stall.
// Commands are stalled while a pass runs; the table rotates one slot a cycle unless a held fire waits on the output.
// Reset: synchronous; it empties the table and sets the lateness window to 15.
// Depends on pal_pkg, pal_head and pal_cell.
`timescale 1ns / 1ps

module periodic_alarm_list_unit #(
  parameter int NUM_SLOTS = pal_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pal_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pal_pkg::rsp_t rsp,
  input  logic          cfg_wen,
  input  logic [15:0]   cfg_wdata
);
  import pal_pkg::*;

  localparam int CW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(NUM_SLOTS - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]            state;
  logic [15:0]           window;
  logic [1:0]            job_cmd;
  logic [7:0]            job_id;
  logic [31:0]           job_first_due;
  logic [31:0]           job_period;
  logic [31:0]           job_now;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         pos;
  logic [FIRE_CNT_W-1:0] fire_cnt;
  scan_flags_t           flg;
  logic                  pend_valid;
  logic [7:0]            pend_id;
  logic [31:0]           pend_due;

  entry_t                cells [NUM_SLOTS];
  entry_t                fb;
  head_res_t             hres;
  cell_ctl_t             ctl;
  logic [NUM_SLOTS-1:0]  vld_vec;

  logic   accept;
  logic   out_free;
  logic   fire_emit;
  logic   step;
  logic   fin_done;
  logic   out_load;
  rsp_t   out_next;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= LATE_WINDOW_RST;
    end else if (cfg_wen) begin
      window <= cfg_wdata;
    end
  end

  // Head evaluation.
  pal_head u_head (
    .cmd       (job_cmd),
    .job_id    (job_id),
    .first_due (job_first_due),
    .period    (job_period),
    .now       (job_now),
    .window    (window),
    .head      (cells[0]),
    .flg       (flg),
    .fb        (fb),
    .res       (hres)
  );

  // A fire that produces a result; it must push any pending fire out first.
  assign fire_emit = hres.fire && (fire_cnt < FIRE_CNT_W'(MAX_RESULTS));
  assign step      = (state == S_SCAN) && !(fire_emit && pend_valid && !out_free);
  assign fin_done  = (state == S_FINISH) && (out_free || ((job_cmd == CMD_TICK) && !pend_valid));

  assign ctl.step    = step;
  assign ctl.compact = fin_done && (job_cmd == CMD_UNREG) && flg.found;

  // Chain of cells; the tail takes the fed-back head on a step, an empty slot on close-up.
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    entry_t nb;
    if (i == NUM_SLOTS - 1) begin : g_tail
      always_comb begin
        nb = fb;
        if (!step) begin
          nb.valid = 1'b0;
        end
      end
    end else begin : g_mid
      assign nb = cells[i + 1];
    end
    pal_cell #(
      .IDX   (i),
      .POS_W (CW)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .pos (pos),
      .nb  (nb),
      .q   (cells[i])
    );
    assign vld_vec[i] = cells[i].valid;
  end

  // Selection of the next result transaction.
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (step && fire_emit && pend_valid) begin
      out_load          = 1'b1;
      out_next.kind     = KIND_FIRE;
      out_next.fired_id = pend_id;
      out_next.next_due = pend_due;
      out_next.status   = ST_OK;
      out_next.last     = 1'b0;
    end else if (fin_done && (job_cmd == CMD_TICK) && pend_valid) begin
      out_load          = 1'b1;
      out_next.kind     = KIND_FIRE;
      out_next.fired_id = pend_id;
      out_next.next_due = pend_due;
      out_next.status   = ST_OK;
      out_next.last     = 1'b1;
    end else if (fin_done && (job_cmd != CMD_TICK)) begin
      out_load          = 1'b1;
      out_next.kind     = KIND_STATUS;
      out_next.fired_id = job_id;
      out_next.next_due = '0;
      out_next.last     = 1'b1;
      if (job_cmd == CMD_REG) begin
        out_next.status = flg.dup ? ST_DUP : (flg.placed ? ST_OK : ST_FULL);
      end else begin
        out_next.status = flg.found ? ST_OK : ST_NOT_FOUND;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= out_next;
    end
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      fire_cnt   <= '0;
      flg        <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (req.cmd != CMD_NOP)) begin
            state      <= S_SCAN;
            cnt        <= '0;
            fire_cnt   <= '0;
            flg        <= '0;
            pend_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          if (step) begin
            if (fire_emit) begin
              pend_valid <= 1'b1;
              fire_cnt   <= fire_cnt + FIRE_CNT_W'(1);
            end
            if (hres.match && (job_cmd == CMD_REG)) begin
              flg.dup <= 1'b1;
            end
            if (hres.match && (job_cmd == CMD_UNREG)) begin
              flg.found <= 1'b1;
            end
            if (hres.place) begin
              flg.placed <= 1'b1;
            end
            if (cnt == CNT_LAST) begin
              state <= S_FINISH;
            end else begin
              cnt <= cnt + CW'(1);
            end
          end
        end
        S_FINISH: begin
          if (fin_done) begin
            state      <= S_IDLE;
            pend_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Job fields, pending fire id and due time, and removal position carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      job_cmd       <= req.cmd;
      job_id        <= req.alarm_id;
      job_first_due <= req.first_due;
      job_period    <= req.period;
      job_now       <= req.now;
    end
    if (step && fire_emit) begin
      pend_id  <= cells[0].id;
      pend_due <= fb.due;
    end
    if (step && hres.match && (job_cmd == CMD_UNREG)) begin
      pos <= cnt;
    end
  end

  // A real command locks the input out on the following cycle.
  a_busy_after_cmd : assert property (@(posedge clk) disable iff (rst)
    (accept && (req.cmd != CMD_NOP)) |=> (state == S_SCAN))
    else $error("command accepted but no pass started");

  // Between commands the valid slots form a prefix of the table.
  a_prefix : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((vld_vec & (vld_vec + NUM_SLOTS'(1))) == '0))
    else $error("valid slots are not a prefix");

  // A held fire never outlives its tick.
  a_pend_idle : assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state != S_IDLE))
    else $error("pending fire left after the pass");

  // Status results carry no due time.
  a_status_due : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.kind == KIND_STATUS)) |-> (rsp.next_due == '0))
    else $error("status result with a due time");

endmodule
